/* sv/cms_pkg.sv */
// Package with shared types and constants for the count-min sketch core.
package cms_pkg;

    localparam int unsigned COLUMNS_DEF = 1024;
    localparam int unsigned ROWS_DEF    = 4;
    localparam logic [31:0] HASH_START  = 32'd5381;
    localparam int unsigned HASH_SHIFT  = 5;
    localparam int unsigned REG_W       = 62;
    localparam int unsigned IDX_W       = 3;

    localparam logic [IDX_W-1:0] REG_ROW0   = 3'd0;
    localparam logic [IDX_W-1:0] REG_ROW1   = 3'd1;
    localparam logic [IDX_W-1:0] REG_ROW2   = 3'd2;
    localparam logic [IDX_W-1:0] REG_ROW3   = 3'd3;
    localparam logic [IDX_W-1:0] REG_WIDTH  = 3'd4;
    localparam logic [IDX_W-1:0] REG_THRESH = 3'd5;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_FOLD,
        ST_MOD,
        ST_READ,
        ST_WAIT,
        ST_WRITE,
        ST_NEXT,
        ST_TOTAL,
        ST_OUT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_write;
        logic clr_step;
        logic accept;
        logic hash_step;
        logic mul_lo;
        logic mul_hi;
        logic mod_start;
        logic mod_step;
        logic mem_read;
        logic mem_write;
        logic row_next;
        logic total_upd;
        logic out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_done;
        logic mod_done;
        logic last_row;
        logic out_full;
    } stat_t;

endpackage

/* sv/cms_ram.sv */
// Generic single-port RAM with registered read data.
module cms_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

/* sv/cms_ctrl.sv */
// Controller state machine sequencing the sketch datapath.
module cms_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           in_last,
    input  cms_pkg::stat_t stat,
    output logic           in_ready,
    output cms_pkg::cmd_t  cmd
);

    cms_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cms_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            cms_pkg::ST_CLEAR:
            begin
                cmd.clr_write = 1'b1;
                cmd.clr_step  = 1'b1;
                if (stat.clr_done)
                begin
                    state_next = cms_pkg::ST_IDLE;
                end
            end
            cms_pkg::ST_IDLE:
            begin
                // Every item waits while the previous result is unread.
                in_ready = !stat.out_full;
                if (in_valid && !stat.out_full)
                begin
                    cmd.accept = 1'b1;
                    if (in_last)
                    begin
                        state_next = cms_pkg::ST_MUL_LO;
                    end
                    else
                    begin
                        cmd.hash_step = 1'b1;
                    end
                end
            end
            cms_pkg::ST_MUL_LO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = cms_pkg::ST_MUL_HI;
            end
            cms_pkg::ST_MUL_HI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = cms_pkg::ST_FOLD;
            end
            cms_pkg::ST_FOLD:
            begin
                state_next = cms_pkg::ST_MOD;
                cmd.mod_start = 1'b1;
            end
            cms_pkg::ST_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (stat.mod_done)
                begin
                    state_next = cms_pkg::ST_READ;
                end
            end
            cms_pkg::ST_READ:
            begin
                cmd.mem_read = 1'b1;
                state_next   = cms_pkg::ST_WAIT;
            end
            cms_pkg::ST_WAIT:
            begin
                state_next = cms_pkg::ST_WRITE;
            end
            cms_pkg::ST_WRITE:
            begin
                cmd.mem_write = 1'b1;
                state_next    = cms_pkg::ST_NEXT;
            end
            cms_pkg::ST_NEXT:
            begin
                cmd.row_next = 1'b1;
                if (stat.last_row)
                begin
                    state_next = cms_pkg::ST_TOTAL;
                end
                else
                begin
                    state_next = cms_pkg::ST_MUL_LO;
                end
            end
            cms_pkg::ST_TOTAL:
            begin
                cmd.total_upd = 1'b1;
                state_next    = cms_pkg::ST_OUT;
            end
            cms_pkg::ST_OUT:
            begin
                cmd.out_load = 1'b1;
                state_next   = cms_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = cms_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* sv/cms_dp.sv */
// Datapath: running hash, row hashing, modulo unit, counters and result register.
module cms_dp #(
    parameter int unsigned COLUMNS = cms_pkg::COLUMNS_DEF,
    parameter int unsigned ROWS    = cms_pkg::ROWS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  cms_pkg::cmd_t               cmd,
    output cms_pkg::stat_t              stat,
    input  logic                        cfg_we,
    input  logic [cms_pkg::IDX_W-1:0]   cfg_index,
    input  logic [cms_pkg::REG_W-1:0]   cfg_data,
    input  logic                        kind,
    input  logic [7:0]                  char_code,
    input  logic signed [15:0]          increment,
    output logic signed [31:0]          estimate,
    output logic                        heavy,
    output logic signed [31:0]          total_count,
    output logic                        out_valid,
    input  logic                        out_ready
);

    localparam int unsigned COL_W  = $clog2(COLUMNS);
    localparam int unsigned ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int unsigned DEPTH  = (1 << ROW_W) * (1 << COL_W);
    localparam int unsigned ADDR_W = $clog2(DEPTH);
    localparam int unsigned CW_W   = COL_W + 1;
    localparam int unsigned MOD_CNT_W = 5;

    // Configuration registers.
    logic [cms_pkg::REG_W-1:0] coef_reg [4];
    logic [10:0]               width_reg;
    logic [30:0]               thresh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                coef_reg[i] <= '0;
            end
            width_reg  <= 11'd1024;
            thresh_reg <= 31'h7FFF_FFFF;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cms_pkg::REG_ROW0:   coef_reg[0] <= cfg_data;
                cms_pkg::REG_ROW1:   coef_reg[1] <= cfg_data;
                cms_pkg::REG_ROW2:   coef_reg[2] <= cfg_data;
                cms_pkg::REG_ROW3:   coef_reg[3] <= cfg_data;
                cms_pkg::REG_WIDTH:  width_reg   <= cfg_data[10:0];
                cms_pkg::REG_THRESH: thresh_reg  <= cfg_data[30:0];
                default:             ;
            endcase
        end
    end

    // Columns in use, clamped to one through COLUMNS.
    logic [CW_W-1:0] width_eff;
    always_comb
    begin
        if (width_reg == 11'd0)
        begin
            width_eff = CW_W'(1);
        end
        else if (32'(width_reg) > COLUMNS)
        begin
            width_eff = CW_W'(COLUMNS);
        end
        else
        begin
            width_eff = CW_W'(width_reg);
        end
    end

    // Running hash and latched item fields.
    logic [31:0]        hash_reg, key_reg;
    logic               kind_reg;
    logic signed [15:0] inc_reg;
    logic [31:0]        hash_next;

    assign hash_next = (hash_reg << cms_pkg::HASH_SHIFT) + hash_reg + 32'(char_code);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= cms_pkg::HASH_START;
        end
        else if (cmd.accept)
        begin
            hash_reg <= cmd.hash_step ? hash_next : cms_pkg::HASH_START;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            key_reg  <= hash_next;
            kind_reg <= kind;
            inc_reg  <= increment;
        end
    end

    // Row counter.
    logic [ROW_W-1:0] row_reg;
    logic [1:0]       row_sel;
    assign row_sel = 2'(row_reg);
    assign stat.last_row = (32'(row_reg) == ROWS - 1);

    // a*x+b in two 31x16 partial products.
    logic [30:0] coef_a, coef_b;
    logic [62:0] prod_reg;
    logic [46:0] part_lo;
    logic [46:0] part_hi;
    assign coef_a  = coef_reg[row_sel][61:31];
    assign coef_b  = coef_reg[row_sel][30:0];
    assign part_lo = 47'(coef_a) * 47'(key_reg[15:0]);
    assign part_hi = 47'(coef_a) * 47'(key_reg[31:16]);

    logic [63:0] fold_sum;
    assign fold_sum = 64'(prod_reg >> 31) + 64'(prod_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.mul_lo)
        begin
            prod_reg <= 63'(part_lo) + 63'(coef_b);
        end
        else if (cmd.mul_hi)
        begin
            prod_reg <= prod_reg + (63'(part_hi) << 16);
        end
    end

    // Restoring remainder unit, one bit per cycle over the 31 folded bits.
    logic [30:0]          mod_q_reg;
    logic [CW_W-1:0]      mod_r_reg;
    logic [MOD_CNT_W-1:0] mod_cnt_reg;
    logic [CW_W:0]        mod_trial;
    assign mod_trial = {mod_r_reg, mod_q_reg[30]};
    assign stat.mod_done = (mod_cnt_reg == MOD_CNT_W'(30));

    always_ff @(posedge clk)
    begin
        if (cmd.mod_start)
        begin
            mod_q_reg   <= fold_sum[30:0];
            mod_r_reg   <= '0;
            mod_cnt_reg <= '0;
        end
        else if (cmd.mod_step)
        begin
            mod_q_reg   <= mod_q_reg << 1;
            mod_cnt_reg <= mod_cnt_reg + MOD_CNT_W'(1);
            if (mod_trial >= (CW_W+1)'(width_eff))
            begin
                mod_r_reg <= CW_W'(mod_trial - (CW_W+1)'(width_eff));
            end
            else
            begin
                mod_r_reg <= CW_W'(mod_trial);
            end
        end
    end

    // Counter memory, cleared by a sweep after reset.
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] ram_addr;
    logic [31:0]       ram_wdata, ram_rdata;
    logic              ram_we;
    assign stat.clr_done = (clr_addr_reg == ADDR_W'(DEPTH - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clr_step && !stat.clr_done)
        begin
            clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_read)
        begin
            addr_reg <= ADDR_W'({row_reg, mod_r_reg[COL_W-1:0]});
        end
    end

    // Saturating add of a 16-bit increment to a 32-bit signed value.
    function automatic logic [31:0] sat_add(input logic [31:0] base,
                                            input logic signed [15:0] d);
        logic signed [32:0] s;
        s = $signed({base[31], base}) + 33'(d);
        if (s > 33'sh0_7FFF_FFFF)
        begin
            return 32'h7FFF_FFFF;
        end
        else if (s < -33'sh0_8000_0000)
        begin
            return 32'h8000_0000;
        end
        return s[31:0];
    endfunction

    logic upd;
    assign upd = !kind_reg;

    assign ram_we    = cmd.clr_write || cmd.mem_write;
    assign ram_addr  = cmd.clr_write ? clr_addr_reg :
                       (cmd.mem_read ? ADDR_W'({row_reg, mod_r_reg[COL_W-1:0]}) : addr_reg);
    assign ram_wdata = cmd.clr_write ? 32'd0 :
                       (upd ? sat_add(ram_rdata, inc_reg) : ram_rdata);

    cms_ram #(
        .WIDTH(32),
        .DEPTH(DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Minimum over rows and running total.
    logic signed [31:0] min_reg, total_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg   <= '0;
            total_reg <= '0;
        end
        else
        begin
            if (cmd.row_next)
            begin
                row_reg <= stat.last_row ? '0 : row_reg + ROW_W'(1);
            end
            if (cmd.total_upd && upd)
            begin
                total_reg <= sat_add(total_reg, inc_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_write)
        begin
            if (row_reg == '0 || $signed(ram_wdata) < min_reg)
            begin
                min_reg <= ram_wdata;
            end
        end
    end

    // Result register.
    logic out_valid_reg;
    assign stat.out_full = out_valid_reg;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            estimate    <= min_reg;
            total_count <= total_reg;
            heavy       <= upd && (min_reg >= $signed({1'b0, thresh_reg}));
        end
    end

endmodule

/* sv/count_min_sketch_string_core.sv */
// Top level of the count-min sketch core for string keys.
// Keys arrive one character per item; each character that is not the last
// folds into a 32-bit djb2 hash. The last character starts the per-row work:
// for each row, a*x+b is formed from a low and a high partial product, folded
// by adding its bits above bit 30 to it and keeping the low 31 bits, reduced
// modulo the columns in use by a bit-serial remainder unit, and the counter is
// read, saturating-updated when kind is low (else left unchanged), and written
// back in the single-port counter RAM. No new item is taken until the key's
// rows are done and its result is loaded. One result item is produced per key.
// After reset a clearing pass zeroes the counter RAM, one
// entry a cycle, before the first item is taken. The RAM has as many entries
// as the row count (at least two) times COLUMNS, each rounded up to a power of
// two (4096 by default). Configuration writes are taken throughout. Every item
// is held off while the previous result is still waiting to be taken.
module count_min_sketch_string_core #(
    parameter int unsigned COLUMNS = cms_pkg::COLUMNS_DEF,
    parameter int unsigned ROWS    = cms_pkg::ROWS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [cms_pkg::IDX_W-1:0] cfg_index,
    input  logic [cms_pkg::REG_W-1:0] cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      kind,
    input  logic [7:0]                char_code,
    input  logic                      last,
    input  logic signed [15:0]        increment,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [31:0]        estimate,
    output logic                      heavy,
    output logic signed [31:0]        total_count
);

    cms_pkg::cmd_t  cmd;
    cms_pkg::stat_t stat;

    cms_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_last   (last),
        .stat      (stat),
        .in_ready  (in_ready),
        .cmd       (cmd)
    );

    cms_dp #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .kind        (kind),
        .char_code   (char_code),
        .increment   (increment),
        .estimate    (estimate),
        .heavy       (heavy),
        .total_count (total_count),
        .out_valid   (out_valid),
        .out_ready   (out_ready)
    );

endmodule
